### hw/rtl/shfh_pkg.sv
// ----------------------------------------------------------------------------
// shfh_pkg: shared types and mixing functions for the string hash
// Group mix, tail mix and the two halves of the final avalanche.
// ----------------------------------------------------------------------------
package shfh_pkg;

  localparam int unsigned HashW  = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 16;
  localparam int unsigned PendW  = 24;
  localparam int unsigned PosW   = 2;

  localparam logic [PosW-1:0] PosLast = 2'd3;
  localparam logic [PosW-1:0] RemOne  = 2'd1;
  localparam logic [PosW-1:0] RemTwo  = 2'd2;
  localparam logic [PosW-1:0] RemThr  = 2'd3;

  // Snapshot of a finished message, handed to the finishing pipeline
  typedef struct packed {
    logic [HashW-1:0] acc;
    logic [PosW-1:0]  rem;
    logic [PendW-1:0] pend;
    logic             empty;
  } fin_req_t;

  function automatic logic [HashW-1:0] mix_group(input logic [HashW-1:0] h_in,
                                                 input logic [15:0]      lo,
                                                 input logic [15:0]      hi);
    logic [HashW-1:0] h;
    logic [HashW-1:0] t;
    h = h_in + {16'b0, lo};
    t = ({16'b0, hi} << 11) ^ h;
    h = (h << 16) ^ t;
    h = h + (h >> 11);
    return h;
  endfunction

  function automatic logic [HashW-1:0] sext8(input logic [ByteW-1:0] b);
    return {{(HashW-ByteW){b[ByteW-1]}}, b};
  endfunction

  function automatic logic [HashW-1:0] tail_mix(input logic [HashW-1:0] h_in,
                                                input logic [PosW-1:0]  rem,
                                                input logic [PendW-1:0] pend);
    logic [HashW-1:0] h;
    h = h_in;
    case (rem)
      RemThr: begin
        h = h + {16'b0, pend[15:0]};
        h = h ^ (h << 16);
        h = h ^ (sext8(pend[23:16]) << 18);
        h = h + (h >> 11);
      end
      RemTwo: begin
        h = h + {16'b0, pend[15:0]};
        h = h ^ (h << 11);
        h = h + (h >> 17);
      end
      RemOne: begin
        h = h + sext8(pend[7:0]);
        h = h ^ (h << 10);
        h = h + (h >> 1);
      end
      default: h = h_in;
    endcase
    return h;
  endfunction

  function automatic logic [HashW-1:0] aval_lo(input logic [HashW-1:0] h_in);
    logic [HashW-1:0] h;
    h = h_in ^ (h_in << 3);
    h = h + (h >> 5);
    h = h ^ (h << 4);
    return h;
  endfunction

  function automatic logic [HashW-1:0] aval_hi(input logic [HashW-1:0] h_in);
    logic [HashW-1:0] h;
    h = h_in + (h_in >> 17);
    h = h ^ (h << 25);
    h = h + (h >> 6);
    return h;
  endfunction

endpackage

### hw/rtl/shfh_accum.sv
// ----------------------------------------------------------------------------
// shfh_accum: input register and running accumulator
// Registers each byte item, folds complete groups of four into the hash and
// hands a snapshot to the finishing pipeline on the last byte.
// ----------------------------------------------------------------------------
module shfh_accum #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [shfh_pkg::ByteW-1:0]   byte_i,
  input  logic                         first_i,
  input  logic                         last_i,
  input  logic [shfh_pkg::LenW-1:0]    len_i,
  output logic                         fin_valid_o,
  input  logic                         fin_ready_i,
  output shfh_pkg::fin_req_t           fin_req_o
);

  localparam int unsigned MaskBits = (LENGTH_BITS < shfh_pkg::LenW) ? LENGTH_BITS
                                                                    : shfh_pkg::LenW;
  localparam logic [shfh_pkg::LenW-1:0] LenMask =
    shfh_pkg::LenW'((33'd1 << MaskBits) - 33'd1);

  // input register
  logic                         in_vld_q;
  logic [shfh_pkg::ByteW-1:0]   byte_q;
  logic                         first_q;
  logic                         last_q;
  logic [shfh_pkg::LenW-1:0]    len_q;

  // message state
  logic [shfh_pkg::HashW-1:0]   acc_q, acc_d;
  logic [shfh_pkg::PendW-1:0]   pend_q, pend_d;
  logic [shfh_pkg::PosW-1:0]    pos_q, pos_d;
  logic                         empty_q, empty_d;

  logic [shfh_pkg::HashW-1:0]   acc_b, acc_n;
  logic [shfh_pkg::PendW-1:0]   pend_b, pend_n;
  logic [shfh_pkg::PosW-1:0]    pos_b, pos_n;
  logic                         empty_b;
  logic [shfh_pkg::LenW-1:0]    seed;
  logic                         adv;

  assign adv        = in_vld_q & (~last_q | fin_ready_i);
  assign in_ready_o = ~in_vld_q | ~last_q | fin_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q  <= byte_i;
      first_q <= first_i;
      last_q  <= last_i;
      len_q   <= len_i;
    end
  end

  always_comb begin
    seed    = len_q & LenMask;
    acc_b   = first_q ? {16'b0, seed} : acc_q;
    pend_b  = first_q ? '0 : pend_q;
    pos_b   = first_q ? '0 : pos_q;
    empty_b = first_q ? (seed == '0) : empty_q;

    if (pos_b == shfh_pkg::PosLast) begin
      acc_n  = shfh_pkg::mix_group(acc_b, pend_b[15:0], {byte_q, pend_b[23:16]});
      pend_n = '0;
      pos_n  = '0;
    end else begin
      acc_n  = acc_b;
      pend_n = pend_b;
      case (pos_b)
        2'd0:    pend_n[7:0]   = byte_q;
        2'd1:    pend_n[15:8]  = byte_q;
        default: pend_n[23:16] = byte_q;
      endcase
      pos_n  = pos_b + 2'd1;
    end

    // a finished message leaves the state as after reset
    if (last_q) begin
      acc_d   = '0;
      pend_d  = '0;
      pos_d   = '0;
      empty_d = 1'b0;
    end else begin
      acc_d   = acc_n;
      pend_d  = pend_n;
      pos_d   = pos_n;
      empty_d = empty_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      pend_q  <= '0;
      pos_q   <= '0;
      empty_q <= 1'b0;
    end else if (adv) begin
      acc_q   <= acc_d;
      pend_q  <= pend_d;
      pos_q   <= pos_d;
      empty_q <= empty_d;
    end
  end

  assign fin_valid_o     = in_vld_q & last_q;
  assign fin_req_o.acc   = acc_n;
  assign fin_req_o.rem   = pos_n;
  assign fin_req_o.pend  = pend_n;
  assign fin_req_o.empty = empty_b;

endmodule

### hw/rtl/shfh_finish.sv
// ----------------------------------------------------------------------------
// shfh_finish: tail mix and avalanche pipeline
// Three stages: snapshot register, tail mix with the first avalanche half,
// second half into the output register. Every stage moves on when the one
// after it has room.
// ----------------------------------------------------------------------------
module shfh_finish (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  shfh_pkg::fin_req_t          req_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [shfh_pkg::HashW-1:0]  hash_o
);

  logic                        s1_vld_q, s2_vld_q, s3_vld_q;
  logic                        s1_rdy, s2_rdy, s3_rdy;
  shfh_pkg::fin_req_t          s1_q;
  logic [shfh_pkg::HashW-1:0]  s2_h_q, s3_h_q;
  logic                        s2_empty_q;

  assign s3_rdy      = ~s3_vld_q | out_ready_i;
  assign s2_rdy      = ~s2_vld_q | s3_rdy;
  assign s1_rdy      = ~s1_vld_q | s2_rdy;
  assign req_ready_o = s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_vld_q <= req_valid_i;
      if (s2_rdy) s2_vld_q <= s1_vld_q;
      if (s3_rdy) s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && req_valid_i) begin
      s1_q <= req_i;
    end
    if (s2_rdy && s1_vld_q) begin
      s2_h_q     <= shfh_pkg::aval_lo(shfh_pkg::tail_mix(s1_q.acc, s1_q.rem, s1_q.pend));
      s2_empty_q <= s1_q.empty;
    end
    if (s3_rdy && s2_vld_q) begin
      // zero-length message hashes to zero
      s3_h_q <= s2_empty_q ? '0 : shfh_pkg::aval_hi(s2_h_q);
    end
  end

  assign out_valid_o = s3_vld_q;
  assign hash_o      = s3_h_q;

endmodule

### hw/rtl/streaming_32bit_string_hash.sv
// ----------------------------------------------------------------------------
// streaming_32bit_string_hash: 32-bit string hash over a byte stream
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tdata: data_byte, message_length
//                                       tuser: first_byte, tlast: last_byte
// m_axis    out  tvalid/tready          tdata: hash_value
// One byte item is taken per cycle unless a last byte waits for the finishing
// stages; the group mix sits between input register and accumulator. The hash
// passes input register, snapshot stage, tail mix with first avalanche half
// and second half in the output register, then m_axis_tvalid rises.
// Reset clears all valid flags and the message state; no clearing pass.
// A stalled output fills the three finishing stages; the next last byte then
// waits in the input register and holds s_axis_tready low.
// ----------------------------------------------------------------------------
module streaming_32bit_string_hash #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] data_byte, [23:8] message_length
  input  logic        s_axis_tuser,   // [0] first_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] hash_value
);

  logic               fin_valid;
  logic               fin_ready;
  shfh_pkg::fin_req_t fin_req;

  shfh_accum #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .byte_i      (s_axis_tdata[7:0]),
    .first_i     (s_axis_tuser),
    .last_i      (s_axis_tlast),
    .len_i       (s_axis_tdata[23:8]),
    .fin_valid_o (fin_valid),
    .fin_ready_i (fin_ready),
    .fin_req_o   (fin_req)
  );

  shfh_finish u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (fin_valid),
    .req_ready_o (fin_ready),
    .req_i       (fin_req),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .hash_o      (m_axis_tdata)
  );

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the streaming 32-bit string hash
// Feeds keys one byte per item, predicts each finished hash, checks the
// output stream in order under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CycleLimit = 300000;

  // Running hash state of the block; one expected hash per last byte
  class hash_tracker;
    logic [shfh_pkg::HashW-1:0] acc;
    logic [shfh_pkg::PendW-1:0] held;
    logic [shfh_pkg::PosW-1:0]  fill;
    bit                         zero_seed;
    logic [shfh_pkg::HashW-1:0] due_hashes[$];
    int                         errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      acc       = '0;
      held      = '0;
      fill      = '0;
      zero_seed = 1'b0;
    endfunction

    function int pending();
      return due_hashes.size();
    endfunction

    function logic [shfh_pkg::HashW-1:0] widen(input logic [shfh_pkg::ByteW-1:0] b);
      return {{(shfh_pkg::HashW-shfh_pkg::ByteW){b[shfh_pkg::ByteW-1]}}, b};
    endfunction

    function void take_byte(input logic [shfh_pkg::ByteW-1:0] d, input logic first,
                            input logic last, input logic [shfh_pkg::LenW-1:0] len);
      logic [shfh_pkg::HashW-1:0] h;
      if (first) begin
        acc       = shfh_pkg::HashW'(len);
        held      = '0;
        fill      = '0;
        zero_seed = (len == '0);
      end
      if (fill == shfh_pkg::PosLast) begin
        // full group: low half from the held bytes, high half completed by d
        h    = acc + {16'b0, held[15:0]};
        h    = (h << 16) ^ ({16'b0, d, held[23:16]} << 11) ^ h;
        acc  = h + (h >> 11);
        held = '0;
        fill = '0;
      end else begin
        held[8*fill +: 8] = d;
        fill++;
      end
      if (!last) return;
      h = acc;
      case (fill)
        shfh_pkg::RemThr: begin
          h += {16'b0, held[15:0]};
          h ^= h << 16;
          h ^= widen(held[23:16]) << 18;
          h += h >> 11;
        end
        shfh_pkg::RemTwo: begin
          h += {16'b0, held[15:0]};
          h ^= h << 11;
          h += h >> 17;
        end
        shfh_pkg::RemOne: begin
          h += widen(held[7:0]);
          h ^= h << 10;
          h += h >> 1;
        end
        default: ;
      endcase
      h ^= h << 3;
      h += h >> 5;
      h ^= h << 4;
      h += h >> 17;
      h ^= h << 25;
      h += h >> 6;
      due_hashes.push_back(zero_seed ? '0 : h);
      clear();
    endfunction

    function void match_hash(input logic [shfh_pkg::HashW-1:0] got);
      logic [shfh_pkg::HashW-1:0] want;
      if (due_hashes.size() == 0) begin
        $display("%0t: unexpected hash, expected none, actual %08h", $time, got);
        errors++;
      end else begin
        want = due_hashes.pop_front();
        if (got !== want) begin
          $display("%0t: hash mismatch, expected %08h, actual %08h", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // [7:0] data_byte, [23:8] message_length
  logic        s_axis_tuser  = 1'b0; // [0] first_byte
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [31:0] hash_value

  hash_tracker board;
  int          tx_idle    = 20;
  int          rx_idle    = 68;
  int          hold_req   = 0;
  int          hold_left  = 0;
  int          items_sent = 0;
  int unsigned cycles     = 0;

  streaming_32bit_string_hash uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Output side: check each hash taken, then pick the next ready level
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) board.match_hash(m_axis_tdata);
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  task automatic push_byte(input logic [shfh_pkg::ByteW-1:0] d, input logic first,
                           input logic last, input logic [shfh_pkg::LenW-1:0] len);
    while ($urandom_range(0, 99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {len, d};
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.take_byte(d, first, last, len);
    items_sent++;
  endtask

  // Length only matters on the first item; later items carry random noise there
  task automatic send_message(input int n, input bit with_first, input bit with_last,
                              input logic [shfh_pkg::LenW-1:0] len);
    for (int i = 0; i < n; i++) begin
      push_byte(shfh_pkg::ByteW'($urandom_range(0, 255)), with_first && i == 0,
                with_last && i == n - 1,
                (i == 0) ? len : shfh_pkg::LenW'($urandom));
    end
  endtask

  task automatic wait_hashes();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(input int goal);
    int                          kind;
    int                          n;
    logic [shfh_pkg::LenW-1:0]   len;
    while (items_sent < goal) begin
      kind = $urandom_range(0, 99);
      n    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      case ($urandom_range(0, 5))
        0:       len = '0;
        1:       len = '1;
        2:       len = shfh_pkg::LenW'($urandom);
        default: len = shfh_pkg::LenW'(n);
      endcase
      if (kind < 80)      send_message(n, 1'b1, 1'b1, len);
      else if (kind < 90) send_message(n, 1'b0, 1'b1, len);  // no first byte, continues from whatever state is held
      else                send_message(n, 1'b1, 1'b0, len);  // cut off, next first restarts
    end
  endtask

  initial begin
    board = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one-byte message with the odd byte negative
    push_byte(8'h80, 1'b1, 1'b1, 16'd1);
    // zero length: hash is 0 whatever bytes follow
    push_byte(8'hff, 1'b1, 1'b0, 16'd0);
    push_byte(8'h12, 1'b0, 1'b0, 16'hffff);
    push_byte(8'h80, 1'b0, 1'b1, 16'd0);
    // two-byte tail
    push_byte(8'hff, 1'b1, 1'b0, 16'd2);
    push_byte(8'h00, 1'b0, 1'b1, 16'd0);
    // three-byte tail, top byte sign-extended
    push_byte(8'h01, 1'b1, 1'b0, 16'd3);
    push_byte(8'h02, 1'b0, 1'b0, 16'd0);
    push_byte(8'hff, 1'b0, 1'b1, 16'd0);
    // exactly one group, largest seed
    push_byte(8'hff, 1'b1, 1'b0, 16'hffff);
    push_byte(8'hff, 1'b0, 1'b0, 16'hffff);
    push_byte(8'hff, 1'b0, 1'b0, 16'hffff);
    push_byte(8'hff, 1'b0, 1'b1, 16'hffff);
    // one group plus a single positive byte
    push_byte(8'h00, 1'b1, 1'b0, 16'd5);
    push_byte(8'h00, 1'b0, 1'b0, 16'd0);
    push_byte(8'h00, 1'b0, 1'b0, 16'd0);
    push_byte(8'h00, 1'b0, 1'b0, 16'd0);
    push_byte(8'h7f, 1'b0, 1'b1, 16'd0);
    // no first byte after a finished message: zero seed but still hashed
    push_byte(8'h5a, 1'b0, 1'b0, 16'd7);
    push_byte(8'ha5, 1'b0, 1'b1, 16'd7);
    // length disagrees with the byte count
    push_byte(8'h10, 1'b1, 1'b0, 16'd9);
    push_byte(8'h20, 1'b0, 1'b0, 16'd0);
    push_byte(8'h30, 1'b0, 1'b1, 16'd0);

    run_random(520);
    wait_hashes();

    tx_idle = 68;
    rx_idle = 20;
    run_random(1040);
    wait_hashes();

    // no idling; a long output hold first backs up the finishing stages
    tx_idle  = 0;
    rx_idle  = 0;
    hold_req = 300;
    run_random(1550);
    wait_hashes();
    repeat (20) @(posedge clk_i);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
